@@ rtl/whd_pkg.sv @@
// whd_pkg: types, codes and constants of the WAV header deframer.
// No dependencies; imported by the core.
`default_nettype none

package whd_pkg;

    // Chunk tags as they appear in the file, first byte in the top byte
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] LIST_LIMIT_RESET = 32'd1000;

    // Byte offsets inside the fixed part of the header, and the last offset of a 4-byte word
    localparam logic [5:0] OFS_RIFF_LAST  = 6'd3;
    localparam logic [5:0] OFS_WAVE_LAST  = 6'd11;
    localparam logic [5:0] OFS_CHANNELS   = 6'd22;
    localparam logic [5:0] OFS_RATE_LAST  = 6'd27;
    localparam logic [5:0] OFS_BITS       = 6'd34;
    localparam logic [5:0] OFS_TAG1_LAST  = 6'd39;
    localparam logic [5:0] OFS_WORD4_LAST = 6'd3;

    typedef enum logic [2:0] {
        PH_FIXED   = 3'd0,
        PH_LISTLEN = 3'd1,
        PH_SKIP    = 3'd2,
        PH_TAG2    = 3'd3,
        PH_SIZE    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DONE    = 3'd6,
        PH_ERROR   = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HEADER   = 3'd0,
        KIND_COMPLETE = 3'd1,
        KIND_PAYLOAD  = 3'd2,
        KIND_ERROR    = 3'd3,
        KIND_IGNORED  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_RIFF   = 3'd1,
        ERR_NO_WAVE   = 3'd2,
        ERR_NO_DATA   = 3'd3,
        ERR_EARLY_END = 3'd4,
        ERR_LIST_LONG = 3'd5
    } t_err;

endpackage

`default_nettype wire

@@ rtl/whd_if.sv @@
// whd_if: valid/ready channels of the WAV header deframer.
// whd_in_if carries file bytes, whd_out_if carries result words.
`default_nettype none

interface whd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;
    logic       file_end;

    modport source (output valid, output data_byte, output file_start,
                    output file_end, input ready);
    modport sink   (input valid, input data_byte, input file_start,
                    input file_end, output ready);
endinterface

interface whd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  error_code;
    logic [7:0]  channels;
    logic [31:0] sample_rate;
    logic [7:0]  bits_per_sample;
    logic [31:0] data_size;
    logic [7:0]  payload_byte;
    logic        payload_last;

    modport source (output valid, output kind, output error_code, output channels,
                    output sample_rate, output bits_per_sample, output data_size,
                    output payload_byte, output payload_last, input ready);
    modport sink   (input valid, input kind, input error_code, input channels,
                     input sample_rate, input bits_per_sample, input data_size,
                     input payload_byte, input payload_last, output ready);
endinterface

`default_nettype wire

@@ rtl/wav_header_deframer_core.sv @@
// wav_header_deframer_core: RIFF/WAVE header parser and payload pass-through.
// Depends on whd_pkg and the channels in whd_if.sv.
//
//   channel   direction  handshake        word
//   i_in      in         valid / ready    data_byte, file_start, file_end
//   o_out     out        valid / ready    kind, error_code, captured fields,
//                                         payload_byte, payload_last
//   i_cfg_*   in         write enable     list_skip_limit (32 bits)
//
// One result word per input word; o_out.valid rises in the cycle after accept.
// Throughput is one word per cycle: the parser update for a byte is a shift,
// a compare or a count step, done between the input channel and the result
// register, so the only limit is the single result register.
// i_in.ready is low only while a result waits and o_out.ready is low.
// Reset (synchronous, active low) clears the parser and restores the limit
// register to 1000; file_start clears the parser for the byte it comes with.
`default_nettype none

module wav_header_deframer_core
    import whd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [31:0] i_cfg_wdata,
    whd_in_if.sink      i_in,
    whd_out_if.source   o_out
);

    // Parser state
    t_phase      r_phase,    n_phase;
    logic [5:0]  r_offset,   n_offset;
    logic [31:0] r_tag,      n_tag;
    logic [31:0] r_accum,    n_accum;
    logic [31:0] r_skip_rem, n_skip_rem;
    logic [7:0]  r_channels, n_channels;
    logic [31:0] r_rate,     n_rate;
    logic [7:0]  r_bits,     n_bits;
    logic [31:0] r_size,     n_size;
    logic [31:0] r_pay_rem,  n_pay_rem;
    t_err        r_err,      n_err;
    logic [31:0] r_limit;

    // Result register
    logic        r_out_valid;
    t_kind       r_kind,     n_kind;
    t_err        r_err_code, n_err_code;
    logic [7:0]  r_pbyte,    n_pbyte;
    logic        r_plast,    n_plast;

    // State as seen by this byte, after a possible file restart
    t_phase      s_phase;
    logic [5:0]  s_offset;
    logic [31:0] s_tag, s_accum, s_skip_rem, s_rate, s_size, s_pay_rem;
    logic [7:0]  s_channels, s_bits;
    t_err        s_err;
    t_err        new_err;
    logic [7:0]  b;
    logic        accept;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    always_comb begin
        // file_start restarts the parser before the byte is used
        s_phase    = i_in.file_start ? PH_FIXED : r_phase;
        s_offset   = i_in.file_start ? 6'd0  : r_offset;
        s_tag      = i_in.file_start ? 32'd0 : r_tag;
        s_accum    = i_in.file_start ? 32'd0 : r_accum;
        s_skip_rem = i_in.file_start ? 32'd0 : r_skip_rem;
        s_channels = i_in.file_start ? 8'd0  : r_channels;
        s_rate     = i_in.file_start ? 32'd0 : r_rate;
        s_bits     = i_in.file_start ? 8'd0  : r_bits;
        s_size     = i_in.file_start ? 32'd0 : r_size;
        s_pay_rem  = i_in.file_start ? 32'd0 : r_pay_rem;
        s_err      = i_in.file_start ? ERR_NONE : r_err;

        n_phase    = s_phase;
        n_offset   = s_offset;
        n_tag      = s_tag;
        n_accum    = s_accum;
        n_skip_rem = s_skip_rem;
        n_channels = s_channels;
        n_rate     = s_rate;
        n_bits     = s_bits;
        n_size     = s_size;
        n_pay_rem  = s_pay_rem;
        n_err      = s_err;
        n_kind     = KIND_HEADER;
        n_pbyte    = 8'd0;
        n_plast    = 1'b0;
        new_err    = ERR_NONE;

        unique case (s_phase)
            PH_ERROR: begin
                n_kind = KIND_ERROR;
            end
            PH_DONE: begin
                n_kind = KIND_IGNORED;
            end
            PH_PAYLOAD: begin
                n_kind  = KIND_PAYLOAD;
                n_pbyte = b;
                if (s_pay_rem <= 32'd1) begin
                    n_pay_rem = 32'd0;
                    n_plast   = 1'b1;
                    n_phase   = PH_DONE;
                end else begin
                    n_pay_rem = s_pay_rem - 32'd1;
                    if (i_in.file_end) begin
                        new_err = ERR_EARLY_END;
                    end
                end
            end
            PH_FIXED, PH_LISTLEN, PH_SKIP, PH_TAG2, PH_SIZE: begin
                // Shift the byte into both the tag view and the LE field view
                n_tag    = {s_tag[23:0], b};
                n_accum  = {b, s_accum[31:8]};
                n_offset = s_offset + 6'd1;
                unique case (s_phase)
                    PH_FIXED: begin
                        priority if (s_offset == OFS_RIFF_LAST && n_tag != TAG_RIFF) begin
                            new_err = ERR_NO_RIFF;
                        end else if (s_offset == OFS_WAVE_LAST && n_tag != TAG_WAVE) begin
                            new_err = ERR_NO_WAVE;
                        end else if (s_offset == OFS_CHANNELS) begin
                            n_channels = b;
                        end else if (s_offset == OFS_RATE_LAST) begin
                            n_rate = n_accum;
                        end else if (s_offset == OFS_BITS) begin
                            n_bits = b;
                        end else if (s_offset >= OFS_TAG1_LAST) begin
                            n_offset = 6'd0;
                            priority if (n_tag == TAG_LIST) begin
                                n_phase = PH_LISTLEN;
                            end else if (n_tag == TAG_DATA) begin
                                n_phase = PH_SIZE;
                            end else begin
                                new_err = ERR_NO_DATA;
                            end
                        end else begin
                            n_phase = s_phase;
                        end
                    end
                    PH_LISTLEN: begin
                        if (s_offset >= OFS_WORD4_LAST) begin
                            n_offset = 6'd0;
                            priority if (n_accum > r_limit) begin
                                new_err = ERR_LIST_LONG;
                            end else if (n_accum == 32'd0) begin
                                n_phase = PH_TAG2;
                            end else begin
                                n_skip_rem = n_accum;
                                n_phase    = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_offset = 6'd0;
                        if (s_skip_rem <= 32'd1) begin
                            n_skip_rem = 32'd0;
                            n_phase    = PH_TAG2;
                        end else begin
                            n_skip_rem = s_skip_rem - 32'd1;
                        end
                    end
                    PH_TAG2: begin
                        if (s_offset >= OFS_WORD4_LAST) begin
                            n_offset = 6'd0;
                            if (n_tag == TAG_DATA) begin
                                n_phase = PH_SIZE;
                            end else begin
                                new_err = ERR_NO_DATA;
                            end
                        end
                    end
                    default: begin
                        // data size word
                        if (s_offset >= OFS_WORD4_LAST) begin
                            n_offset = 6'd0;
                            n_size   = n_accum;
                            n_kind   = KIND_COMPLETE;
                            if (n_accum == 32'd0) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_pay_rem = n_accum;
                                n_phase   = PH_PAYLOAD;
                            end
                        end
                    end
                endcase
                // End of file inside the header; a tag error wins
                if (new_err == ERR_NONE && i_in.file_end && n_phase != PH_DONE) begin
                    new_err = ERR_EARLY_END;
                end
            end
            default: begin
                n_kind = KIND_ERROR;
            end
        endcase

        // Latch a new error and report it on this byte
        if (new_err != ERR_NONE) begin
            n_err   = new_err;
            n_phase = PH_ERROR;
            n_kind  = KIND_ERROR;
            n_pbyte = 8'd0;
            n_plast = 1'b0;
        end

        n_err_code = (n_kind == KIND_ERROR) ? n_err : ERR_NONE;
    end

    // Control and captured state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIXED;
            r_offset    <= 6'd0;
            r_tag       <= 32'd0;
            r_accum     <= 32'd0;
            r_skip_rem  <= 32'd0;
            r_channels  <= 8'd0;
            r_rate      <= 32'd0;
            r_bits      <= 8'd0;
            r_size      <= 32'd0;
            r_pay_rem   <= 32'd0;
            r_err       <= ERR_NONE;
            r_limit     <= LIST_LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (accept) begin
                r_phase    <= n_phase;
                r_offset   <= n_offset;
                r_tag      <= n_tag;
                r_accum    <= n_accum;
                r_skip_rem <= n_skip_rem;
                r_channels <= n_channels;
                r_rate     <= n_rate;
                r_bits     <= n_bits;
                r_size     <= n_size;
                r_pay_rem  <= n_pay_rem;
                r_err      <= n_err;
            end
            // Hold the word while stalled, drop valid once taken
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word payload: loaded on accept only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= n_kind;
            r_err_code <= n_err_code;
            r_pbyte    <= n_pbyte;
            r_plast    <= n_plast;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_kind;
    assign o_out.error_code      = r_err_code;
    assign o_out.channels        = r_channels;
    assign o_out.sample_rate     = r_rate;
    assign o_out.bits_per_sample = r_bits;
    assign o_out.data_size       = r_size;
    assign o_out.payload_byte    = r_pbyte;
    assign o_out.payload_last    = r_plast;

    // An error result leaves the parser in the error phase
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_kind == KIND_ERROR) |=> (r_phase == PH_ERROR && r_err != ERR_NONE))
        else $error("error result did not latch the error phase");

    // A waiting, untaken result blocks new input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while result stalled");

    // Payload phase always has bytes left to pass
    a_pay_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_pay_rem != 32'd0))
        else $error("payload phase with zero bytes remaining");

    // Last payload byte moves the parser to done
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_plast) |=> (r_phase == PH_DONE && o_out.kind == KIND_PAYLOAD))
        else $error("last payload byte did not finish the file");

endmodule

`default_nettype wire
